// File: rtl/dsrc_pkg.sv
// ---------------------------------------------------------------------------
// dsrc_pkg - door servo ramp controller package
// Shared types, register map, reset values and the button selection rule.
// ---------------------------------------------------------------------------
package dsrc_pkg;

    // width of the servo position register
    localparam int unsigned ANGLE_BITS = 8;
    localparam logic [ANGLE_BITS-1:0] POS_MAX = {ANGLE_BITS{1'b1}};

    localparam int unsigned CFG_W      = 8;
    localparam int unsigned STEP_W     = 5;
    localparam int unsigned COMPARE_W  = 10;
    localparam int unsigned PADDR_W    = 5;
    localparam int unsigned PDATA_W    = 32;

    typedef enum logic [2:0] {
        ST_OPENING = 3'd0,
        ST_CLOSING = 3'd1,
        ST_STOPPED = 3'd2,
        ST_CLOSED  = 3'd3,
        ST_OPEN    = 3'd4
    } door_mode_t;

    typedef enum logic [2:0] {
        REG_OPEN_ANGLE   = 3'd0,
        REG_CLOSED_ANGLE = 3'd1,
        REG_STEP_SIZE    = 3'd2,
        REG_BASE_COMPARE = 3'd3,
        REG_MAX_ANGLE    = 3'd4
    } reg_index_t;

    localparam logic [CFG_W-1:0]  OPEN_ANGLE_RST   = 8'd90;
    localparam logic [CFG_W-1:0]  CLOSED_ANGLE_RST = 8'd0;
    localparam logic [STEP_W-1:0] STEP_SIZE_RST    = 5'd1;
    localparam logic [CFG_W-1:0]  BASE_COMPARE_RST = 8'd88;
    localparam logic [CFG_W-1:0]  MAX_ANGLE_RST    = 8'd180;

    // state a button press would move to
    function automatic door_mode_t press_target(door_mode_t mode, door_mode_t prior);
        door_mode_t res;
        unique case (mode)
            ST_OPEN:    res = ST_CLOSING;
            ST_CLOSED:  res = ST_OPENING;
            ST_STOPPED: res = (prior == ST_CLOSING) ? ST_OPENING : ST_CLOSING;
            default:    res = ST_STOPPED;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/door_servo_ramp_controller_core.sv
// ---------------------------------------------------------------------------
// door_servo_ramp_controller_core - door servo ramp controller
// Tick and request beats step the servo angle and the door state; each beat
// yields the state, a changed flag, the pwm compare value and the button
// target. Control registers sit on an apb-style port.
// ---------------------------------------------------------------------------
// result: registered; each result beat is valid in the cycle after its input beat
// throughput: one beat per cycle; the output register is reloaded in the same
//   cycle its result is taken, so only a stalled result holds off input
// reset: asynchronous, active low; door closed, prior state closing, angle
//   zero, registers at their defaults, no result pending
module door_servo_ramp_controller_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 cmd,
    input  logic [2:0]                           target_state,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [2:0]                           door_state,
    output logic                                 state_changed,
    output logic [dsrc_pkg::COMPARE_W-1:0]       pulse_compare,
    output logic [2:0]                           button_next,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dsrc_pkg::PADDR_W-1:0]         paddr,
    input  logic [dsrc_pkg::PDATA_W-1:0]         pwdata,
    output logic [dsrc_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    localparam int unsigned AW = dsrc_pkg::ANGLE_BITS;
    localparam int unsigned CW = dsrc_pkg::CFG_W;
    localparam int unsigned SW = dsrc_pkg::STEP_W;
    localparam int unsigned PW = dsrc_pkg::COMPARE_W;
    localparam int unsigned DW = dsrc_pkg::PDATA_W;

    logic [CW-1:0] open_angle_reg;
    logic [CW-1:0] closed_angle_reg;
    logic [SW-1:0] step_size_reg;
    logic [CW-1:0] base_compare_reg;
    logic [CW-1:0] max_angle_reg;

    dsrc_pkg::door_mode_t door_mode_reg, door_mode_next;
    dsrc_pkg::door_mode_t prior_mode_reg, prior_mode_next;
    logic [AW-1:0]        servo_pos_reg, servo_pos_next;

    logic                 out_valid_reg;
    logic [2:0]           door_state_reg;
    logic                 changed_reg, changed_next;
    logic [PW-1:0]        compare_reg, compare_next;
    logic [2:0]           button_reg;

    logic                 in_beat;
    logic                 cfg_write;
    dsrc_pkg::reg_index_t cfg_index;
    logic                 mode_req;
    logic                 target_ok;
    dsrc_pkg::door_mode_t mode_target;
    logic [AW:0]          pos_sum;
    logic [AW-1:0]        step_ext;
    logic [AW-1:0]        open_ext;
    logic [AW-1:0]        closed_ext;
    logic [AW-1:0]        max_ext;
    logic [CW-1:0]        angle;

    assign in_beat   = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = dsrc_pkg::reg_index_t'(paddr[4:2]);

    // ---------------- register port ----------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_angle_reg   <= dsrc_pkg::OPEN_ANGLE_RST;
            closed_angle_reg <= dsrc_pkg::CLOSED_ANGLE_RST;
            step_size_reg    <= dsrc_pkg::STEP_SIZE_RST;
            base_compare_reg <= dsrc_pkg::BASE_COMPARE_RST;
            max_angle_reg    <= dsrc_pkg::MAX_ANGLE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dsrc_pkg::REG_OPEN_ANGLE:   open_angle_reg   <= pwdata[CW-1:0];
                dsrc_pkg::REG_CLOSED_ANGLE: closed_angle_reg <= pwdata[CW-1:0];
                dsrc_pkg::REG_STEP_SIZE:    step_size_reg    <= pwdata[SW-1:0];
                dsrc_pkg::REG_BASE_COMPARE: base_compare_reg <= pwdata[CW-1:0];
                dsrc_pkg::REG_MAX_ANGLE:    max_angle_reg    <= pwdata[CW-1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            dsrc_pkg::REG_OPEN_ANGLE:   prdata = DW'(open_angle_reg);
            dsrc_pkg::REG_CLOSED_ANGLE: prdata = DW'(closed_angle_reg);
            dsrc_pkg::REG_STEP_SIZE:    prdata = DW'(step_size_reg);
            dsrc_pkg::REG_BASE_COMPARE: prdata = DW'(base_compare_reg);
            dsrc_pkg::REG_MAX_ANGLE:    prdata = DW'(max_angle_reg);
            default:                    prdata = '0;
        endcase
    end

    // ---------------- state update ----------------

    assign step_ext   = AW'(step_size_reg);
    assign open_ext   = AW'(open_angle_reg);
    assign closed_ext = AW'(closed_angle_reg);
    assign max_ext    = AW'(max_angle_reg);
    assign pos_sum    = {1'b0, servo_pos_reg} + {1'b0, step_ext};

    assign target_ok   = (target_state <= 3'(dsrc_pkg::ST_OPEN));
    assign mode_target = dsrc_pkg::door_mode_t'(target_state);

    always_comb
    begin
        servo_pos_next = servo_pos_reg;
        mode_req       = 1'b0;
        door_mode_next = door_mode_reg;
        if (cmd)
        begin
            if (target_ok)
            begin
                mode_req       = 1'b1;
                door_mode_next = mode_target;
            end
        end
        else
        begin
            case (door_mode_reg)
                dsrc_pkg::ST_OPENING:
                begin
                    if (servo_pos_reg >= open_ext)
                    begin
                        mode_req       = 1'b1;
                        door_mode_next = dsrc_pkg::ST_OPEN;
                    end
                    else
                        servo_pos_next = pos_sum[AW] ? dsrc_pkg::POS_MAX : pos_sum[AW-1:0];
                end
                dsrc_pkg::ST_CLOSING:
                begin
                    if (servo_pos_reg <= closed_ext)
                    begin
                        mode_req       = 1'b1;
                        door_mode_next = dsrc_pkg::ST_CLOSED;
                    end
                    // floor at zero on the last step down
                    else
                        servo_pos_next = (servo_pos_reg > step_ext) ?
                                         (servo_pos_reg - step_ext) : '0;
                end
                default: ;
            endcase
        end
        // prior state only moves on a real change
        changed_next    = mode_req && (door_mode_next != door_mode_reg);
        prior_mode_next = changed_next ? door_mode_reg : prior_mode_reg;
        if (!changed_next)
            door_mode_next = door_mode_reg;
    end

    // clamp before the compare; a clamped angle always fits the register width
    assign angle        = (servo_pos_next > max_ext) ? max_angle_reg : servo_pos_next[CW-1:0];
    assign compare_next = PW'(base_compare_reg) + PW'({angle, 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            door_mode_reg  <= dsrc_pkg::ST_CLOSED;
            prior_mode_reg <= dsrc_pkg::ST_CLOSING;
            servo_pos_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                door_mode_reg  <= door_mode_next;
                prior_mode_reg <= prior_mode_next;
                servo_pos_reg  <= servo_pos_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            door_state_reg <= door_mode_next;
            changed_reg    <= changed_next;
            compare_reg    <= compare_next;
            button_reg     <= dsrc_pkg::press_target(door_mode_next, prior_mode_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign door_state    = door_state_reg;
    assign state_changed = changed_reg;
    assign pulse_compare = compare_reg;
    assign button_next   = button_reg;

    // ---------------- assertions ----------------

    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_changed == (door_mode_reg != $past(door_mode_reg))))
        else $error("changed flag disagrees with state update");

    a_prior_differs: assert property (@(posedge clk) disable iff (!rst_n)
        prior_mode_reg != door_mode_reg)
        else $error("prior state equals current state");

    a_hold_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && (cmd || (door_mode_reg != dsrc_pkg::ST_OPENING &&
                              door_mode_reg != dsrc_pkg::ST_CLOSING)))
        |=> (servo_pos_reg == $past(servo_pos_reg)))
        else $error("angle moved without a movement tick");

    a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (door_state == 3'(door_mode_reg)))
        else $error("result state differs from door state");

endmodule

// File: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top - door servo ramp controller core testbench
// Drives tick and request beats through the valid/ready input, programs the
// five control registers over the apb-style port between phases, and checks
// every result beat against a cycle-free model of the door state, servo angle,
// compare value and button target. Both sides idle in random bursts.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int unsigned RESET_CYCLES    = 12;
    localparam int unsigned RAND_PHASES     = 12;
    localparam int unsigned PHASE_BEATS     = 128;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned LONG_HOLD       = 300;
    localparam int unsigned REG_SLOTS       = 5;
    localparam int unsigned TIMEOUT_TIME    = 2000000;

    typedef struct packed {
        dsrc_pkg::door_mode_t               mode;
        logic                               changed;
        logic [dsrc_pkg::COMPARE_W-1:0]     compare;
        dsrc_pkg::door_mode_t               press;
    } door_beat_t;

    typedef struct packed {
        logic       is_req;
        logic [2:0] tgt;
        logic       pinned;
        door_beat_t want;
    } dir_row_t;

    localparam door_beat_t ANY_BEAT = '0;

    // opening rows run at the reset register values
    localparam dir_row_t DIR_ROWS [22] = '{
        '{1'b0, 3'd0, 1'b1,
          '{dsrc_pkg::ST_CLOSED,  1'b0, 10'd88, dsrc_pkg::ST_OPENING}},
        '{1'b1, 3'd5, 1'b1,
          '{dsrc_pkg::ST_CLOSED,  1'b0, 10'd88, dsrc_pkg::ST_OPENING}},
        '{1'b1, 3'd6, 1'b1,
          '{dsrc_pkg::ST_CLOSED,  1'b0, 10'd88, dsrc_pkg::ST_OPENING}},
        '{1'b1, 3'd7, 1'b1,
          '{dsrc_pkg::ST_CLOSED,  1'b0, 10'd88, dsrc_pkg::ST_OPENING}},
        '{1'b1, dsrc_pkg::ST_CLOSED, 1'b1,
          '{dsrc_pkg::ST_CLOSED,  1'b0, 10'd88, dsrc_pkg::ST_OPENING}},
        '{1'b0, 3'd7, 1'b1,
          '{dsrc_pkg::ST_CLOSED,  1'b0, 10'd88, dsrc_pkg::ST_OPENING}},
        '{1'b1, dsrc_pkg::ST_OPENING, 1'b1,
          '{dsrc_pkg::ST_OPENING, 1'b1, 10'd88, dsrc_pkg::ST_STOPPED}},
        '{1'b1, dsrc_pkg::ST_OPENING, 1'b1,
          '{dsrc_pkg::ST_OPENING, 1'b0, 10'd88, dsrc_pkg::ST_STOPPED}},
        '{1'b0, 3'd3, 1'b1,
          '{dsrc_pkg::ST_OPENING, 1'b0, 10'd90, dsrc_pkg::ST_STOPPED}},
        '{1'b0, 3'd0, 1'b0, ANY_BEAT},
        '{1'b1, dsrc_pkg::ST_STOPPED, 1'b1,
          '{dsrc_pkg::ST_STOPPED, 1'b1, 10'd92, dsrc_pkg::ST_CLOSING}},
        '{1'b0, 3'd4, 1'b1,
          '{dsrc_pkg::ST_STOPPED, 1'b0, 10'd92, dsrc_pkg::ST_CLOSING}},
        '{1'b1, dsrc_pkg::ST_CLOSING, 1'b1,
          '{dsrc_pkg::ST_CLOSING, 1'b1, 10'd92, dsrc_pkg::ST_STOPPED}},
        '{1'b0, 3'd1, 1'b0, ANY_BEAT},
        '{1'b0, 3'd2, 1'b0, ANY_BEAT},
        '{1'b0, 3'd0, 1'b1,
          '{dsrc_pkg::ST_CLOSED,  1'b1, 10'd88, dsrc_pkg::ST_OPENING}},
        '{1'b1, dsrc_pkg::ST_STOPPED, 1'b1,
          '{dsrc_pkg::ST_STOPPED, 1'b1, 10'd88, dsrc_pkg::ST_CLOSING}},
        '{1'b1, dsrc_pkg::ST_CLOSING, 1'b1,
          '{dsrc_pkg::ST_CLOSING, 1'b1, 10'd88, dsrc_pkg::ST_STOPPED}},
        '{1'b1, dsrc_pkg::ST_STOPPED, 1'b1,
          '{dsrc_pkg::ST_STOPPED, 1'b1, 10'd88, dsrc_pkg::ST_OPENING}},
        '{1'b1, dsrc_pkg::ST_OPEN, 1'b1,
          '{dsrc_pkg::ST_OPEN,    1'b1, 10'd88, dsrc_pkg::ST_CLOSING}},
        '{1'b0, 3'd6, 1'b1,
          '{dsrc_pkg::ST_OPEN,    1'b0, 10'd88, dsrc_pkg::ST_CLOSING}},
        '{1'b1, 3'd5, 1'b1,
          '{dsrc_pkg::ST_OPEN,    1'b0, 10'd88, dsrc_pkg::ST_CLOSING}}
    };

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic                               cmd;
    logic [2:0]                         target_state;
    logic                               out_valid;
    logic                               out_ready;
    logic [2:0]                         door_state;
    logic                               state_changed;
    logic [dsrc_pkg::COMPARE_W-1:0]     pulse_compare;
    logic [2:0]                         button_next;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [dsrc_pkg::PADDR_W-1:0]       paddr;
    logic [dsrc_pkg::PDATA_W-1:0]       pwdata;
    logic [dsrc_pkg::PDATA_W-1:0]       prdata;
    logic                               pready;

    // predicted door state and register copy
    dsrc_pkg::door_mode_t               pred_mode   = dsrc_pkg::ST_CLOSED;
    dsrc_pkg::door_mode_t               pred_prior  = dsrc_pkg::ST_CLOSING;
    logic [dsrc_pkg::ANGLE_BITS-1:0]    pred_pos    = '0;
    logic [dsrc_pkg::CFG_W-1:0]         cfg_open    = dsrc_pkg::OPEN_ANGLE_RST;
    logic [dsrc_pkg::CFG_W-1:0]         cfg_closed  = dsrc_pkg::CLOSED_ANGLE_RST;
    logic [dsrc_pkg::STEP_W-1:0]        cfg_step    = dsrc_pkg::STEP_SIZE_RST;
    logic [dsrc_pkg::CFG_W-1:0]         cfg_base    = dsrc_pkg::BASE_COMPARE_RST;
    logic [dsrc_pkg::CFG_W-1:0]         cfg_max     = dsrc_pkg::MAX_ANGLE_RST;

    door_beat_t             door_beats_due [$];
    int unsigned            errors          = 0;
    int unsigned            beats_sent      = 0;
    int unsigned            beats_checked   = 0;
    int unsigned            reached_open    = 0;
    int unsigned            reached_closed  = 0;
    int unsigned            ignored_reqs    = 0;
    int unsigned            sender_idle_pct = 0;
    int unsigned            sink_idle_pct   = 0;
    bit                     long_hold       = 1'b0;

    door_servo_ramp_controller_core i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .target_state   (target_state),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .door_state     (door_state),
        .state_changed  (state_changed),
        .pulse_compare  (pulse_compare),
        .button_next    (button_next),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 clk = ~clk;

    function automatic bit move_door(dsrc_pkg::door_mode_t to);
        if (to == pred_mode)
            return 1'b0;
        pred_prior = pred_mode;
        pred_mode  = to;
        return 1'b1;
    endfunction

    task automatic step_door(input logic is_req, input logic [2:0] tgt, output door_beat_t r);
        int unsigned sum;
        int unsigned ang;
        r.changed = 1'b0;
        if (is_req) begin
            if (tgt <= dsrc_pkg::ST_OPEN)
                r.changed = move_door(dsrc_pkg::door_mode_t'(tgt));
            else
                ignored_reqs++;
        end else if (pred_mode == dsrc_pkg::ST_OPENING) begin
            if (pred_pos >= cfg_open) begin
                r.changed = move_door(dsrc_pkg::ST_OPEN);
                reached_open++;
            end else begin
                sum      = 32'(pred_pos) + 32'(cfg_step);
                pred_pos = (sum > 32'(dsrc_pkg::POS_MAX)) ? dsrc_pkg::POS_MAX :
                           sum[dsrc_pkg::ANGLE_BITS-1:0];
            end
        end else if (pred_mode == dsrc_pkg::ST_CLOSING) begin
            if (pred_pos <= cfg_closed) begin
                r.changed = move_door(dsrc_pkg::ST_CLOSED);
                reached_closed++;
            end else begin
                pred_pos = (pred_pos > cfg_step) ? pred_pos - cfg_step : '0;
            end
        end
        ang       = (pred_pos > cfg_max) ? 32'(cfg_max) : 32'(pred_pos);
        r.mode    = pred_mode;
        r.compare = dsrc_pkg::COMPARE_W'(32'(cfg_base) + 2 * ang);
        case (pred_mode)
            dsrc_pkg::ST_OPEN:    r.press = dsrc_pkg::ST_CLOSING;
            dsrc_pkg::ST_CLOSED:  r.press = dsrc_pkg::ST_OPENING;
            dsrc_pkg::ST_STOPPED: r.press = (pred_prior == dsrc_pkg::ST_CLOSING) ?
                                            dsrc_pkg::ST_OPENING : dsrc_pkg::ST_CLOSING;
            default:              r.press = dsrc_pkg::ST_STOPPED;
        endcase
    endtask

    // leaves psel high so that writes can follow back to back
    task automatic write_reg(input int unsigned idx, input logic [dsrc_pkg::PDATA_W-1:0] val);
        logic [dsrc_pkg::PDATA_W-1:0] mask;
        mask    = (idx == dsrc_pkg::REG_STEP_SIZE) ? 32'h1F : 32'hFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dsrc_pkg::PADDR_W'(idx * 4);
        pwdata  <= $urandom_range(0, 1) ? ((val & mask) | ($urandom & ~mask)) : (val & mask);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            dsrc_pkg::REG_OPEN_ANGLE:   cfg_open   = val[dsrc_pkg::CFG_W-1:0];
            dsrc_pkg::REG_CLOSED_ANGLE: cfg_closed = val[dsrc_pkg::CFG_W-1:0];
            dsrc_pkg::REG_STEP_SIZE:    cfg_step   = val[dsrc_pkg::STEP_W-1:0];
            dsrc_pkg::REG_BASE_COMPARE: cfg_base   = val[dsrc_pkg::CFG_W-1:0];
            dsrc_pkg::REG_MAX_ANGLE:    cfg_max    = val[dsrc_pkg::CFG_W-1:0];
            default:                    ;
        endcase
    endtask

    task automatic offer(input logic is_req, input logic [2:0] tgt, input logic pinned,
                         input door_beat_t fixed);
        door_beat_t want;
        in_valid     <= 1'b1;
        cmd          <= is_req;
        target_state <= tgt;
        do @(posedge clk); while (!in_ready);
        step_door(is_req, tgt, want);
        door_beats_due.push_back(pinned ? fixed : want);
        beats_sent++;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic settle();
        while (door_beats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure_phase(input int unsigned ph);
        int unsigned n;
        case (ph)
            1: begin
                write_reg(dsrc_pkg::REG_OPEN_ANGLE, 180);
                write_reg(dsrc_pkg::REG_CLOSED_ANGLE, 0);
                write_reg(dsrc_pkg::REG_STEP_SIZE, 16);
                write_reg(dsrc_pkg::REG_BASE_COMPARE, 255);
                write_reg(dsrc_pkg::REG_MAX_ANGLE, 180);
            end
            2: begin
                // saturating angle, widest step, and writes past the register map
                write_reg(dsrc_pkg::REG_OPEN_ANGLE, 255);
                write_reg(dsrc_pkg::REG_CLOSED_ANGLE, 200);
                write_reg(dsrc_pkg::REG_STEP_SIZE, 31);
                write_reg(dsrc_pkg::REG_BASE_COMPARE, 0);
                write_reg(dsrc_pkg::REG_MAX_ANGLE, 0);
                write_reg(REG_SLOTS, 32'hFFFF_FFFF);
                write_reg(REG_SLOTS + 1, 32'hFFFF_FFFF);
                write_reg(REG_SLOTS + 2, 32'h0000_0000);
            end
            3: begin
                write_reg(dsrc_pkg::REG_STEP_SIZE, 0);
                write_reg(dsrc_pkg::REG_OPEN_ANGLE, 40);
                write_reg(dsrc_pkg::REG_CLOSED_ANGLE, 20);
                write_reg(dsrc_pkg::REG_BASE_COMPARE, 100);
                write_reg(dsrc_pkg::REG_MAX_ANGLE, 255);
            end
            4: begin
                write_reg(dsrc_pkg::REG_OPEN_ANGLE, 0);
                write_reg(dsrc_pkg::REG_CLOSED_ANGLE, 180);
                write_reg(dsrc_pkg::REG_STEP_SIZE, 1);
                write_reg(dsrc_pkg::REG_BASE_COMPARE, 128);
                write_reg(dsrc_pkg::REG_MAX_ANGLE, 90);
            end
            5: begin
                write_reg(dsrc_pkg::REG_OPEN_ANGLE, 180);
                write_reg(dsrc_pkg::REG_CLOSED_ANGLE, 255);
                write_reg(dsrc_pkg::REG_STEP_SIZE, 7);
                write_reg(dsrc_pkg::REG_BASE_COMPARE, 255);
                write_reg(dsrc_pkg::REG_MAX_ANGLE, 255);
            end
            default: begin
                n = 0;
                while (n == 0) begin
                    if ($urandom_range(0, 3) != 0) begin
                        write_reg(dsrc_pkg::REG_OPEN_ANGLE, $urandom_range(0, 9) == 0 ?
                                  $urandom_range(0, 255) : $urandom_range(0, 180));
                        n++;
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        write_reg(dsrc_pkg::REG_CLOSED_ANGLE, $urandom_range(0, 9) == 0 ?
                                  $urandom_range(0, 255) : $urandom_range(0, 90));
                        n++;
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        write_reg(dsrc_pkg::REG_STEP_SIZE, $urandom_range(0, 9) == 0 ?
                                  $urandom_range(0, 31) : $urandom_range(1, 16));
                        n++;
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        write_reg(dsrc_pkg::REG_BASE_COMPARE, $urandom_range(0, 255));
                        n++;
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        write_reg(dsrc_pkg::REG_MAX_ANGLE, $urandom_range(0, 255));
                        n++;
                    end
                end
            end
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned run_left;
        int unsigned pick;
        logic        is_req;
        logic [2:0]  tgt;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        cmd          <= 1'b0;
        target_state <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 20;
        sink_idle_pct   = 20;
        for (int i = 0; i < $size(DIR_ROWS); i++)
            offer(DIR_ROWS[i].is_req, DIR_ROWS[i].tgt, DIR_ROWS[i].pinned, DIR_ROWS[i].want);
        in_valid <= 1'b0;

        for (int unsigned ph = 1; ph <= RAND_PHASES; ph++) begin
            settle();
            configure_phase(ph);
            @(posedge clk);
            if (ph == RAND_PHASES || ph % 4 == 3) begin
                sender_idle_pct = 0;
                sink_idle_pct   = 0;
            end else begin
                sender_idle_pct = $urandom_range(5, 30);
                sink_idle_pct   = $urandom_range(5, 30);
            end
            // sink stalls for a long stretch so the core backs up
            if (ph == 2)
                long_hold = 1'b1;
            run_left = 0;
            for (int unsigned k = 0; k < PHASE_BEATS; k++) begin
                if (run_left == 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70) begin
                        is_req   = 1'b1;
                        tgt      = $urandom_range(0, 1) ? dsrc_pkg::ST_OPENING :
                                                          dsrc_pkg::ST_CLOSING;
                        run_left = $urandom_range(1, 40);
                    end else if (pick < 90) begin
                        is_req   = 1'b1;
                        tgt      = 3'($urandom_range(dsrc_pkg::ST_OPENING, dsrc_pkg::ST_OPEN));
                        run_left = $urandom_range(0, 6);
                    end else begin
                        is_req = 1'($urandom_range(0, 1));
                        tgt    = 3'($urandom_range(0, 7));
                    end
                end else begin
                    is_req = 1'b0;
                    tgt    = 3'($urandom_range(0, 7));
                    run_left--;
                end
                offer(is_req, tgt, 1'b0, ANY_BEAT);
            end
            in_valid <= 1'b0;
        end

        settle();
        $display("%0d input beats, %0d result beats checked over %0d register settings",
                 beats_sent, beats_checked, RAND_PHASES + 1);
        $display("ticks ended %0d openings and %0d closings, %0d undefined requests seen",
                 reached_open, reached_closed, ignored_reqs);
        if (errors == 0 && door_beats_due.size() == 0)
            $display("door_servo_ramp_controller_core verification clean");
        else
            $display("door_servo_ramp_controller_core verification failed");
        $finish;
    end

    initial begin : sink
        out_ready <= 1'b1;
        forever begin
            @(posedge clk);
            if (long_hold) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
                out_ready <= 1'b1;
            end else if (rst_n && $urandom_range(0, 99) < sink_idle_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string what, int unsigned want,
                                        logic [dsrc_pkg::COMPARE_W-1:0] got);
        if (got !== dsrc_pkg::COMPARE_W'(want)) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk) begin : result_check
        door_beat_t want;
        if (rst_n && out_valid && out_ready) begin
            if (door_beats_due.size() == 0) begin
                $display("%0t: result beat with nothing expected, state %0d compare %0d",
                         $time, door_state, pulse_compare);
                errors++;
            end else begin
                want = door_beats_due.pop_front();
                check_field("door_state", 32'(want.mode),
                            dsrc_pkg::COMPARE_W'(door_state));
                check_field("state_changed", 32'(want.changed),
                            dsrc_pkg::COMPARE_W'(state_changed));
                check_field("pulse_compare", 32'(want.compare), pulse_compare);
                check_field("button_next", 32'(want.press),
                            dsrc_pkg::COMPARE_W'(button_next));
                beats_checked++;
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_TIME);
        $display("timed out with %0d result beats outstanding", door_beats_due.size());
        $display("door_servo_ramp_controller_core verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dsrc_pkg.sv
rtl/door_servo_ramp_controller_core.sv
tb/tb_top.sv
